// ===== hdl/dct_pkg.sv =====
`timescale 1ns / 1ps
package dct_pkg;
	localparam int N = 8;
	localparam int AREA = N * N;
	localparam int IDX_W = 6;
	localparam int SAMPLE_W = 8;
	localparam int COEF_W = 16;
	localparam int FRAC_BITS = 4;

	// Q1.14 basis constants, row k, column x
	function automatic logic signed [15:0] basis(input logic [2:0] k, input logic [2:0] x);
		logic signed [15:0] t [0:7][0:7];
		t[0] = '{16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585,
			16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585};
		t[1] = '{16'sd16069, 16'sd13623, 16'sd9102, 16'sd3196,
			-16'sd3196, -16'sd9102, -16'sd13623, -16'sd16069};
		t[2] = '{16'sd15137, 16'sd6270, -16'sd6270, -16'sd15137,
			-16'sd15137, -16'sd6270, 16'sd6270, 16'sd15137};
		t[3] = '{16'sd13623, -16'sd3196, -16'sd16069, -16'sd9102,
			16'sd9102, 16'sd16069, 16'sd3196, -16'sd13623};
		t[4] = '{16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585,
			16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585};
		t[5] = '{16'sd9102, -16'sd16069, 16'sd3196, 16'sd13623,
			-16'sd13623, -16'sd3196, 16'sd16069, -16'sd9102};
		t[6] = '{16'sd6270, -16'sd15137, 16'sd15137, -16'sd6270,
			-16'sd6270, 16'sd15137, -16'sd15137, 16'sd6270};
		t[7] = '{16'sd3196, -16'sd9102, 16'sd13623, -16'sd16069,
			16'sd16069, -16'sd13623, 16'sd9102, -16'sd3196};
		return t[k][x];
	endfunction

	// request passed from front to back: which buffer holds a full block
	typedef struct packed {
		logic bank;
	} blk_req_t;
endpackage

// ===== hdl/dct_ram.sv =====
`timescale 1ns / 1ps
module dct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// one write, one registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/dct_front.sv =====
`timescale 1ns / 1ps
module dct_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [dct_pkg::SAMPLE_W-1:0]      sample,
	output logic                              full,
	output logic                              we,
	output logic [dct_pkg::IDX_W:0]           waddr,
	output logic [dct_pkg::SAMPLE_W-1:0]      wdata,
	output logic                              blk_valid,
	output dct_pkg::blk_req_t                 blk_req,
	input  logic                              blk_take,
	input  logic                              bank_free
);
	logic [dct_pkg::IDX_W-1:0] count_q;
	logic                      bank_q;
	logic                      acc;

	// stall while the bank being filled is still owned by the back part
	assign full = !bank_free;
	assign acc = push && !full;
	assign we = acc;
	assign waddr = {bank_q, count_q};
	assign wdata = sample;

	// sample counter, bank toggles after each complete block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q <= 1'b0;
		end else if (acc) begin
			count_q <= count_q + 1'b1;
			if (count_q == dct_pkg::IDX_W'(dct_pkg::AREA - 1))
				bank_q <= !bank_q;
		end
	end

	// two-entry request queue of completed banks
	logic [1:0] qv_q;
	logic [1:0] qb_q;
	logic [1:0] qv_d;
	logic [1:0] qb_d;
	logic       done;
	assign done = acc && (count_q == dct_pkg::IDX_W'(dct_pkg::AREA - 1));
	assign blk_valid = qv_q[0];
	assign blk_req.bank = qb_q[0];

	// shift out on take, then append a finished bank
	always_comb begin
		qv_d = qv_q;
		qb_d = qb_q;
		if (blk_take) begin
			qv_d = {1'b0, qv_q[1]};
			qb_d = {1'b0, qb_q[1]};
		end
		if (done) begin
			if (qv_d[0]) begin
				qv_d[1] = 1'b1;
				qb_d[1] = bank_q;
			end else begin
				qv_d[0] = 1'b1;
				qb_d[0] = bank_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_q <= '0;
			qb_q <= '0;
		end else begin
			qv_q <= qv_d;
			qb_q <= qb_d;
		end
	end
endmodule

// ===== hdl/dct_back.sv =====
`timescale 1ns / 1ps
module dct_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              blk_valid,
	input  dct_pkg::blk_req_t                 blk_req,
	output logic                              blk_take,
	output logic [dct_pkg::IDX_W:0]           raddr,
	input  logic [dct_pkg::SAMPLE_W-1:0]      rdata,
	output logic                              res_valid,
	output logic [dct_pkg::COEF_W-1:0]        res_coef,
	output logic [dct_pkg::IDX_W-1:0]         res_idx,
	output logic                              res_last,
	input  logic                              res_ready
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t                    state_q;
	logic                      bank_q;
	logic [dct_pkg::IDX_W-1:0] uv_q;
	logic [dct_pkg::IDX_W:0]   xy_q;   // sweep counter with one extra step
	logic                      rd_s1;
	logic signed [40:0]        prod_s2;
	logic                      p_s2;
	logic signed [47:0]        acc_q;
	logic                      fin_q;
	logic                      load;

	logic [2:0] u, v, x, y;
	assign u = uv_q[5:3];
	assign v = uv_q[2:0];
	assign x = xy_q[5:3];
	assign y = xy_q[2:0];
	assign raddr = {bank_q, xy_q[5:0]};
	assign blk_take = (state_q == ST_IDLE) && blk_valid;
	assign load = (state_q == ST_OUT) && (!res_valid || res_ready);

	// combined basis weight for this sample, Q2.28
	logic signed [31:0] w_s1;
	always_ff @(posedge clk) begin
		w_s1 <= 32'(dct_pkg::basis(u, x)) * 32'(dct_pkg::basis(v, y));
	end

	// rounding and saturation of the finished sum
	logic signed [47:0] num, mag, q;
	always_comb begin
		num = acc_q <<< (dct_pkg::FRAC_BITS + 1);
		mag = num[47] ? -num : num;
		q = (mag + 48'sd1073741824) >>> 31;
		if (num[47])
			q = -q;
		if (q > 48'sd32767)
			q = 48'sd32767;
		else if (q < -48'sd32768)
			q = -48'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1 <= 1'b0;
			p_s2 <= 1'b0;
			fin_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_RUN) && !xy_q[6];
			p_s2 <= rd_s1;
			fin_q <= (state_q == ST_RUN) && xy_q[6] && !rd_s1 && !p_s2 && !fin_q;
			if (load)
				res_valid <= 1'b1;
			else if (res_valid && res_ready)
				res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (blk_valid)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (fin_q)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load)
						state_q <= (uv_q == dct_pkg::IDX_W'(dct_pkg::AREA - 1)) ?
							ST_IDLE : ST_RUN;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: sweep, multiply, accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= 41'($signed({1'b0, rdata})) * 41'(w_s1);
		if (p_s2)
			acc_q <= acc_q + 48'(prod_s2);
		case (state_q)
			ST_IDLE: begin
				bank_q <= blk_req.bank;
				uv_q <= '0;
				xy_q <= '0;
				acc_q <= '0;
			end
			ST_RUN: begin
				if (!xy_q[6])
					xy_q <= xy_q + 1'b1;
			end
			ST_OUT: begin
				if (load) begin
					res_coef <= q[15:0];
					res_idx <= uv_q;
					res_last <= (uv_q == dct_pkg::IDX_W'(dct_pkg::AREA - 1));
					uv_q <= uv_q + 1'b1;
					xy_q <= '0;
					acc_q <= '0;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/block_dct_8x8.sv =====
`timescale 1ns / 1ps
// Forward 8x8 DCT-II. Push 64 unsigned samples in row-major order; after the
// last one the 64 coefficients (signed, 4 fraction bits, rounded, saturated)
// come out in row-major order with block_last on the final one. Samples go
// into a double-buffered store, so the next block loads while the previous
// one is transformed. Each coefficient is computed in the single
// multiply-accumulate unit, which reads the 64 stored samples, drains its
// pipeline and then loads the result; a result left waiting holds the unit.
// full is raised when both buffers hold blocks whose coefficients have not
// all been taken.
module block_dct_8x8 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   sample,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [15:0]           coefficient,
	output logic [5:0]                   coef_index,
	output logic                         block_last
);
	logic                  we, blk_valid, blk_take, res_valid, bank_free;
	logic [6:0]            waddr, raddr;
	logic [7:0]            wdata, rdata;
	logic [15:0]           coef;
	dct_pkg::blk_req_t     blk_req;
	logic [1:0]            pend_q;

	// count of banks owned by the back part or waiting for it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(we && waddr[5:0] == 6'd63)
				- 2'(res_valid && pop && block_last);
	end
	assign bank_free = (pend_q != 2'd2);

	dct_front u_front (
		.clk, .arst_n, .push, .sample, .full, .we, .waddr, .wdata,
		.blk_valid, .blk_req, .blk_take, .bank_free
	);

	dct_ram #(.WIDTH(dct_pkg::SAMPLE_W), .DEPTH(2 * dct_pkg::AREA)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	dct_back u_back (
		.clk, .arst_n, .blk_valid, .blk_req, .blk_take, .raddr, .rdata,
		.res_valid, .res_coef(coef), .res_idx(coef_index), .res_last(block_last),
		.res_ready(pop)
	);

	assign empty = !res_valid;
	assign coefficient = $signed(coef);
endmodule
